// ----- rtl/bounded_deque_top_assert.svh -----
// Assertion macros used by the bounded deque top level.
`ifndef BOUNDED_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, off while reset is asserted.
`define BD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define BD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BD_ASSERT(lbl, clk, rstn, prop, msg)
`define BD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/bd_pkg.sv -----
// Types and constants for the bounded deque.
package bd_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PUSHED = 2'd0,
    STATUS_POPPED = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  // Per-cell command: move toward the back, move toward the front, or load; plus the back tap select.
  typedef struct packed {
    logic shift_back;
    logic shift_front;
    logic load;
    logic tap_sel;
  } bd_cell_cmd_t;

endpackage

// ----- rtl/bd_if.sv -----
// Valid/ready channel interfaces for the deque's operation and result words.
interface bd_op_if;
  logic                         valid;
  logic                         ready;
  logic [bd_pkg::FUNC_W-1:0]    func;
  logic signed [bd_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface bd_res_if;
  logic                              valid;
  logic                              ready;
  logic [bd_pkg::STATUS_W-1:0]       status;
  logic signed [bd_pkg::VALUE_W-1:0] pop_value;
  logic [bd_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, output status, output pop_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input occupancy,
                  output ready);
endinterface

// ----- rtl/bd_cell.sv -----
// One storage cell of the deque row: holds one entry, trades with its neighbors.
module bd_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  bd_pkg::bd_cell_cmd_t     cmd_i,
  input  logic [VALUE_WIDTH-1:0]   prev_i,
  input  logic [VALUE_WIDTH-1:0]   next_i,
  input  logic [VALUE_WIDTH-1:0]   push_i,
  output logic [VALUE_WIDTH-1:0]   data_o,
  output logic [VALUE_WIDTH-1:0]   tap_o
);
  import bd_pkg::*;

  logic [VALUE_WIDTH-1:0] data_q;
  logic [VALUE_WIDTH-1:0] data_d;

  // Pick the next entry: neighbor toward the front, neighbor toward the back, or load.
  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_back) begin
      data_d = prev_i;
    end else if (cmd_i.shift_front) begin
      data_d = next_i;
    end else if (cmd_i.load) begin
      data_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the back tap only when this cell holds the back entry.
  assign tap_o  = cmd_i.tap_sel ? data_q : '0;

endmodule

// ----- rtl/bounded_deque_top.sv -----
// Bounded deque top level: a row of DEPTH entry cells with front fixed at cell 0.
//
// The deque takes one operation word per clock and returns its result word in the
// following cycle from an output register; a new word is accepted whenever that
// register is empty or is being read in the same cycle, so a stalled result holds
// the input side for exactly as long as it waits. Entries live in a row of cells:
// a push or pop at the front moves every cell one place at once, a push at the
// back loads the cell just past the last entry, and a pop at the back reads that
// last cell through a tap. The capacity register (reset 16) limits pushes, up to
// DEPTH. The user writes it through cfg_we_i/cfg_data_i while idle (unenforced).
// No clearing pass runs after reset; the deque is usable on the first cycle.
module bounded_deque_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bd_pkg::CAP_W-1:0]    cfg_data_i,
  bd_op_if.sink                       in_i,
  bd_res_if.source                    out_o
);
  import bd_pkg::*;

`include "bounded_deque_top_assert.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]          capacity_q;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             count_d;
  logic                      out_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic [STATUS_W-1:0]       status_d;
  logic [VALUE_W-1:0]        pop_q;
  logic [VALUE_W-1:0]        pop_d;
  logic [OCC_W-1:0]          occ_q;

  logic                      accept;
  logic                      is_push;
  logic                      full;
  logic                      empty;
  logic                      do_push;
  logic                      do_pop;
  logic [LW-1:0]             limit;
  logic [VALUE_WIDTH-1:0]    push_store;
  logic [VALUE_WIDTH-1:0]    back_tap;
  logic signed [VALUE_WIDTH-1:0] pop_raw;
  logic [CW-1:0]             last_idx;

  bd_cell_cmd_t              cmd     [DEPTH];
  logic [VALUE_WIDTH-1:0]    cell_q  [DEPTH];
  logic [VALUE_WIDTH-1:0]    cell_tap[DEPTH];

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Handshake and decision.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_push    = (in_i.func == FUNC_PUSH_FRONT) || (in_i.func == FUNC_PUSH_BACK);
  assign limit      = (LW'(capacity_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity_q);
  assign full       = LW'(count_q) >= limit;
  assign empty      = (count_q == '0);
  assign do_push    = accept && is_push && !full;
  assign do_pop     = accept && !is_push && !empty;
  assign last_idx   = count_q - CW'(1);
  assign push_store = VALUE_WIDTH'($unsigned(in_i.push_value));

  // Build the command of each cell.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cmd[k].shift_back  = do_push && (in_i.func == FUNC_PUSH_FRONT);
      cmd[k].shift_front = do_pop && (in_i.func == FUNC_POP_FRONT);
      cmd[k].load        = do_push && (in_i.func == FUNC_PUSH_BACK) &&
                           (count_q == CW'(k));
      cmd[k].tap_sel     = (last_idx == CW'(k));
    end
  end

  // Row of cells; front entry in cell 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_w;
    logic [VALUE_WIDTH-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = push_store;
    end else begin : g_mid
      assign prev_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_q[g];
    end else begin : g_inner
      assign next_w = cell_q[g+1];
    end
    bd_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd[g]),
      .prev_i (prev_w),
      .next_i (next_w),
      .push_i (push_store),
      .data_o (cell_q[g]),
      .tap_o  (cell_tap[g])
    );
  end

  // Merge the back taps; only the last occupied cell drives a value.
  always_comb begin
    back_tap = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_tap = back_tap | cell_tap[k];
    end
  end

  // Form the result word.
  always_comb begin
    count_d  = count_q;
    status_d = STATUS_FULL;
    pop_raw  = '0;
    if (is_push) begin
      if (!full) begin
        status_d = STATUS_PUSHED;
        count_d  = count_q + CW'(1);
      end
    end else if (empty) begin
      status_d = STATUS_EMPTY;
    end else begin
      status_d = STATUS_POPPED;
      count_d  = count_q - CW'(1);
      pop_raw  = (in_i.func == FUNC_POP_FRONT) ? cell_q[0] : back_tap;
    end
    pop_d = VALUE_W'(pop_raw);
  end

  // Advance the count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Hold the result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pop_q    <= pop_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.pop_value = pop_q;
  assign out_o.occupancy = occ_q;

  // Checks.
  `BD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "count beyond DEPTH")
  `BD_ASSERT(a_push_count, clk_i, rst_ni, do_push |=> count_q == $past(count_q) + CW'(1),
             "push did not grow count")
  `BD_ASSERT(a_pop_count, clk_i, rst_ni, do_pop |=> count_q == $past(count_q) - CW'(1),
             "pop did not shrink count")
  `BD_ASSERT(a_refused_stable, clk_i, rst_ni, (accept && !do_push && !do_pop) |=> $stable(count_q),
             "refused word changed count")
  `BD_ASSERT(a_occ_match, clk_i, rst_ni, accept |=> out_valid_q && (occ_q == OCC_W'(count_q)),
             "reported occupancy differs from count")

endmodule
